@@ design/mmce_pkg.sv @@
// Shared types and constants for the min/max column envelope.
package mmce_pkg;

    localparam int TS_W        = 32;
    localparam int TICKS_W     = 16;
    localparam int INDEX_W     = 7;
    localparam int COUNT_W     = 7;
    localparam int COLUMNS     = 109;
    localparam int AXES        = 3;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = 5;

    localparam logic [TICKS_W-1:0] COLUMN_TICKS_RESET = 16'd46;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TS_W-1:0]    timestamp;
        logic [TICKS_W-1:0] ticks;
        logic [INDEX_W-1:0] index;
    } cmd_hdr_t;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_MERGE   = 5'b00010,
        S_DIV     = 5'b00100,
        S_ADVANCE = 5'b01000,
        S_RD_DATA = 5'b10000
    } state_t;

endpackage

@@ design/mmce_fifo.sv @@
// Small synchronous word queue with full and empty flags.
module mmce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/mmce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mmce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

@@ design/mmce_front.sv @@
// Front end: config register, input decode and command queue.
module mmce_front import mmce_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        action,
    input  logic [TS_W-1:0]             timestamp,
    input  logic signed [SAMPLE_BITS-1:0] sample_x,
    input  logic signed [SAMPLE_BITS-1:0] sample_y,
    input  logic signed [SAMPLE_BITS-1:0] sample_z,
    input  logic [INDEX_W-1:0]          read_index,
    input  logic                        cfg_write,
    input  logic [TICKS_W-1:0]          cfg_data,
    output logic                        cmd_valid,
    output cmd_hdr_t                    cmd_hdr,
    output logic [AXES*SAMPLE_BITS-1:0] cmd_samples,
    input  logic                        cmd_take
);

    localparam int HDR_W  = $bits(cmd_hdr_t);
    localparam int SAMP_W = AXES * SAMPLE_BITS;
    localparam int WORD_W = HDR_W + SAMP_W;

    logic [TICKS_W-1:0] span_ticks_reg;
    cmd_hdr_t           in_hdr;
    logic [WORD_W-1:0]  in_word;
    logic [WORD_W-1:0]  out_word;
    logic               q_empty;

    // zero ticks behaves as one tick per column
    always_comb
    begin
        in_hdr.op        = action ? OP_READ : OP_PUSH;
        in_hdr.timestamp = timestamp;
        in_hdr.ticks     = (span_ticks_reg == '0) ? TICKS_W'(1) : span_ticks_reg;
        in_hdr.index     = read_index;
    end

    assign in_word     = {in_hdr, sample_z, sample_y, sample_x};
    assign cmd_hdr     = cmd_hdr_t'(out_word[WORD_W-1 -: HDR_W]);
    assign cmd_samples = out_word[SAMP_W-1:0];
    assign cmd_valid   = !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_ticks_reg <= COLUMN_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            span_ticks_reg <= cfg_data;
        end
    end

    mmce_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_word),
        .full    (full),
        .rd_en   (cmd_take),
        .rd_data (out_word),
        .empty   (q_empty)
    );

endmodule

@@ design/mmce_back.sv @@
// Back end: column ring state, divider, RAM update and column reads.
module mmce_back import mmce_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    input  cmd_hdr_t                               cmd_hdr,
    input  logic [AXES*SAMPLE_BITS-1:0]            cmd_samples,
    output logic                                   cmd_take,
    input  logic                                   res_full,
    output logic                                   res_push,
    output logic [2*AXES*SAMPLE_BITS+COUNT_W:0]    res_data
);

    localparam int POS_W  = $clog2(COLUMNS);
    localparam int CNT_W  = $clog2(COLUMNS + 1);
    localparam int SUM_W  = POS_W + 1;
    localparam int SAMP_W = AXES * SAMPLE_BITS;
    localparam int ROW_W  = 2 * SAMP_W;
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    state_t             state_reg, state_next;
    logic               started_reg, started_next;
    logic [TS_W-1:0]    start_reg, start_next;
    logic [POS_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [COLUMNS-1:0] valid_reg, valid_next;
    logic               hit_reg, hit_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [TS_W-1:0]    ts_reg, ts_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [SAMP_W-1:0]  samp_reg, samp_next;
    logic [TS_W-1:0]    quo_reg, quo_next;
    logic [TICKS_W-1:0] rem_reg, rem_next;

    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [POS_W-1:0]   ram_raddr;
    logic [ROW_W-1:0]   ram_rdata;

    logic [TS_W-1:0]    elapsed;
    logic               in_span;
    logic               hit;
    logic [POS_W-1:0]   wp_inc;
    logic [POS_W-1:0]   oldest;
    logic [SUM_W-1:0]   pos_sum;
    logic [POS_W-1:0]   rd_pos;

    logic [TICKS_W:0]   div_shift;
    logic [TICKS_W:0]   div_diff;
    logic               div_ge;

    logic [SUM_W-1:0]   clear_n;
    logic [SUM_W-1:0]   wp_sum;
    logic [POS_W-1:0]   new_wp;
    logic [SUM_W:0]     fill_sum;
    logic [CNT_W-1:0]   new_filled;
    logic [COLUMNS-1:0] clr_mask;
    logic [ROW_W-1:0]   merged_row;
    logic [ROW_W-1:0]   open_row;

    // read addressing, counted from the oldest column
    assign elapsed = cmd_hdr.timestamp - start_reg;
    assign in_span = (elapsed < TS_W'(cmd_hdr.ticks));
    assign hit     = (CMP_W'(cmd_hdr.index) < CMP_W'(filled_reg));
    assign wp_inc  = (wp_reg == POS_W'(COLUMNS - 1)) ? '0 : wp_reg + 1'b1;
    assign oldest  = (filled_reg == CNT_W'(COLUMNS)) ? wp_inc : '0;
    assign pos_sum = SUM_W'(oldest) + SUM_W'(cmd_hdr.index);
    assign rd_pos  = (pos_sum >= SUM_W'(COLUMNS)) ? POS_W'(pos_sum - SUM_W'(COLUMNS))
                                                 : POS_W'(pos_sum);

    // restoring divider, one quotient bit per cycle
    assign div_shift = {rem_reg, quo_reg[TS_W-1]};
    assign div_ge    = (div_shift >= {1'b0, ticks_reg});
    assign div_diff  = div_shift - {1'b0, ticks_reg};

    // column advance; start moves to timestamp minus remainder
    assign clear_n    = (quo_reg > TS_W'(COLUMNS)) ? SUM_W'(COLUMNS) : SUM_W'(quo_reg);
    assign wp_sum     = SUM_W'(wp_reg) + clear_n;
    assign new_wp     = (wp_sum >= SUM_W'(COLUMNS)) ? POS_W'(wp_sum - SUM_W'(COLUMNS))
                                                   : POS_W'(wp_sum);
    assign fill_sum   = (SUM_W + 1)'(filled_reg) + (SUM_W + 1)'(clear_n);
    assign new_filled = (fill_sum > (SUM_W + 1)'(COLUMNS)) ? CNT_W'(COLUMNS)
                                                          : CNT_W'(fill_sum);

    always_comb
    begin
        logic [SUM_W-1:0] t;
        logic [SUM_W-1:0] d;
        for (int i = 0; i < COLUMNS; i++)
        begin
            t = SUM_W'(i) + SUM_W'(COLUMNS) - SUM_W'(wp_reg) - SUM_W'(1);
            d = (t >= SUM_W'(COLUMNS)) ? t - SUM_W'(COLUMNS) : t;
            clr_mask[i] = (d < clear_n);
        end
    end

    always_comb
    begin
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [SAMPLE_BITS-1:0] mn;
        logic signed [SAMPLE_BITS-1:0] mx;
        for (int a = 0; a < AXES; a++)
        begin
            s  = samp_reg[a*SAMPLE_BITS +: SAMPLE_BITS];
            mn = ram_rdata[a*SAMPLE_BITS +: SAMPLE_BITS];
            mx = ram_rdata[(AXES+a)*SAMPLE_BITS +: SAMPLE_BITS];
            merged_row[a*SAMPLE_BITS +: SAMPLE_BITS]        = (s < mn) ? s : mn;
            merged_row[(AXES+a)*SAMPLE_BITS +: SAMPLE_BITS] = (s > mx) ? s : mx;
        end
    end

    assign open_row = {samp_reg, samp_reg};

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        start_next   = start_reg;
        wp_next      = wp_reg;
        filled_next  = filled_reg;
        valid_next   = valid_reg;
        hit_next     = hit_reg;
        div_cnt_next = div_cnt_reg;
        ts_next      = ts_reg;
        ticks_next   = ticks_reg;
        samp_next    = samp_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cmd_take     = 1'b0;
        res_push     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = wp_reg;
        ram_wdata    = open_row;
        ram_re       = 1'b0;
        ram_raddr    = wp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    ts_next    = cmd_hdr.timestamp;
                    ticks_next = cmd_hdr.ticks;
                    samp_next  = cmd_samples;
                    unique case (cmd_hdr.op)
                        OP_READ:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = rd_pos;
                            hit_next   = hit && valid_reg[rd_pos];
                            state_next = S_RD_DATA;
                        end
                        OP_PUSH:
                        begin
                            if (!started_reg)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = '0;
                                ram_wdata     = {cmd_samples, cmd_samples};
                                started_next  = 1'b1;
                                start_next    = cmd_hdr.timestamp;
                                wp_next       = '0;
                                filled_next   = CNT_W'(1);
                                valid_next[0] = 1'b1;
                            end
                            else if (in_span)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = wp_reg;
                                state_next = S_MERGE;
                            end
                            else
                            begin
                                quo_next     = elapsed;
                                rem_next     = '0;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MERGE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wp_reg;
                ram_wdata  = merged_row;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                rem_next     = div_ge ? div_diff[TICKS_W-1:0] : div_shift[TICKS_W-1:0];
                quo_next     = {quo_reg[TS_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ADVANCE;
                end
            end
            S_ADVANCE:
            begin
                valid_next         = valid_reg & ~clr_mask;
                valid_next[new_wp] = 1'b1;
                wp_next            = new_wp;
                filled_next        = new_filled;
                start_next         = ts_reg - TS_W'(rem_reg);
                ram_we             = 1'b1;
                ram_waddr          = new_wp;
                ram_wdata          = open_row;
                state_next         = S_IDLE;
            end
            S_RD_DATA:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_data = {hit_reg, COUNT_W'(filled_reg), hit_reg ? ram_rdata : ROW_W'(0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            start_reg   <= '0;
            wp_reg      <= '0;
            filled_reg  <= '0;
            valid_reg   <= '0;
            hit_reg     <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            start_reg   <= start_next;
            wp_reg      <= wp_next;
            filled_reg  <= filled_next;
            valid_reg   <= valid_next;
            hit_reg     <= hit_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg    <= ts_next;
        ticks_reg <= ticks_next;
        samp_reg  <= samp_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
    end

    mmce_ram #(
        .WIDTH (ROW_W),
        .DEPTH (COLUMNS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

@@ design/min_max_column_envelope.sv @@
// A read word leaves the column RAM read register, then enters the result queue;
// a full result queue stalls the back end. An open-column push adds a merge state;
// a push that opens a new column runs the 32-step divider and the advance state.
// The input queue takes 2 more words while the back end is busy.
// Reset: asynchronous, active low; clears ring state and valid bits at once,
// the column width returns to 46 ticks. The column RAM is not cleared.
module min_max_column_envelope import mmce_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic [TS_W-1:0]               timestamp,
    input  logic signed [SAMPLE_BITS-1:0] sample_x,
    input  logic signed [SAMPLE_BITS-1:0] sample_y,
    input  logic signed [SAMPLE_BITS-1:0] sample_z,
    input  logic [INDEX_W-1:0]            read_index,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] low_x,
    output logic signed [SAMPLE_BITS-1:0] high_x,
    output logic signed [SAMPLE_BITS-1:0] low_y,
    output logic signed [SAMPLE_BITS-1:0] high_y,
    output logic signed [SAMPLE_BITS-1:0] low_z,
    output logic signed [SAMPLE_BITS-1:0] high_z,
    output logic                          column_valid,
    output logic [COUNT_W-1:0]            column_count,
    input  logic                          cfg_write,
    input  logic [TICKS_W-1:0]            cfg_data
);

    localparam int SAMP_W = AXES * SAMPLE_BITS;
    localparam int ROW_W  = 2 * SAMP_W;
    localparam int RES_W  = ROW_W + COUNT_W + 1;

    logic              cmd_valid;
    cmd_hdr_t          cmd_hdr;
    logic [SAMP_W-1:0] cmd_samples;
    logic              cmd_take;
    logic              res_full;
    logic              res_push;
    logic [RES_W-1:0]  res_in;
    logic [RES_W-1:0]  res_out;

    mmce_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .timestamp   (timestamp),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .sample_z    (sample_z),
        .read_index  (read_index),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_hdr     (cmd_hdr),
        .cmd_samples (cmd_samples),
        .cmd_take    (cmd_take)
    );

    mmce_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_hdr     (cmd_hdr),
        .cmd_samples (cmd_samples),
        .cmd_take    (cmd_take),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_data    (res_in)
    );

    mmce_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign column_valid = res_out[RES_W-1];
    assign column_count = res_out[ROW_W +: COUNT_W];
    assign low_x        = res_out[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign low_y        = res_out[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign low_z        = res_out[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign high_x       = res_out[3*SAMPLE_BITS +: SAMPLE_BITS];
    assign high_y       = res_out[4*SAMPLE_BITS +: SAMPLE_BITS];
    assign high_z       = res_out[5*SAMPLE_BITS +: SAMPLE_BITS];

`ifndef SYNTHESIS
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full queue");

    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("back end took a command from an empty queue");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !column_valid) |-> (low_x == '0 && high_x == '0 && low_y == '0 &&
                                       high_y == '0 && low_z == '0 && high_z == '0))
        else $error("invalid column word carries nonzero extremes");
`endif

endmodule
